[rtl/assert_macros.svh]
// Assertion macros shared by the light-map brighten RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define LMPB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also checks during reset.
`define LMPB_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[rtl/lmpb_pkg.sv]
// Types, constants and gain table for the light-map pixel brighten block.
`timescale 1ns / 1ps

package lmpb_pkg;

    localparam int NUM_LANES = 3;
    localparam int CHAN_W    = 8;
    localparam int CODE_W    = 24;
    localparam int GAIN_W    = 6;
    localparam int PROD_W    = CHAN_W + GAIN_W;
    localparam int RECIP_W   = 13;
    localparam int RECIP_SH  = 16;
    localparam int CFG_IDX_W = 2;

    // floor(p/10) == (p*6554)>>16 for every p below 16384
    localparam logic [RECIP_W-1:0] RECIP_TENTH = 13'd6554;

    localparam logic [CHAN_W-1:0] BRIGHT_LIMIT = 8'd160;
    localparam logic [CHAN_W-1:0] BAND1_MIN    = 8'd40;
    localparam logic [CHAN_W-1:0] BAND2_MIN    = 8'd80;
    localparam logic [CHAN_W-1:0] BAND3_MIN    = 8'd120;

    localparam logic [CODE_W-1:0] STRONG_RST = 24'hFFFF00;
    localparam logic [CODE_W-1:0] MEDIUM_RST = 24'hFFFF64;
    localparam logic [CODE_W-1:0] SOFT_RST   = 24'hFFFFC8;

    localparam logic [CFG_IDX_W-1:0] CFG_STRONG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT   = 2'd2;

    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_STRONG,
        TBL_MEDIUM,
        TBL_SOFT
    } t_table;

    typedef struct packed {
        logic   valid;
        t_table tbl;
        logic   bright;
    } t_lane_ctl;

    typedef logic [CHAN_W-1:0] t_chan;

    // Gain in tenths for a channel below BRIGHT_LIMIT.
    function automatic logic [GAIN_W-1:0] gain_tenths(t_table tbl, logic bright, t_chan v);
        logic [1:0]        band;
        logic [GAIN_W-1:0] g;
        if (v < BAND1_MIN)      band = 2'd0;
        else if (v < BAND2_MIN) band = 2'd1;
        else if (v < BAND3_MIN) band = 2'd2;
        else                    band = 2'd3;
        g = 6'd10;
        if (bright) begin
            g = (tbl == TBL_SOFT && band == 2'd0) ? 6'd12 : 6'd11;
        end else begin
            case (tbl)
                TBL_STRONG: begin
                    case (band)
                        2'd0:    g = 6'd40;
                        2'd1:    g = 6'd20;
                        2'd2:    g = 6'd17;
                        default: g = 6'd13;
                    endcase
                end
                TBL_MEDIUM: begin
                    case (band)
                        2'd0:    g = 6'd30;
                        2'd1:    g = 6'd17;
                        2'd2:    g = 6'd15;
                        default: g = 6'd13;
                    endcase
                end
                TBL_SOFT: begin
                    case (band)
                        2'd0:    g = 6'd20;
                        2'd1:    g = 6'd15;
                        2'd2:    g = 6'd13;
                        default: g = 6'd12;
                    endcase
                end
                default: g = 6'd10;
            endcase
        end
        return g;
    endfunction

endpackage

[rtl/lmpb_front.sv]
// Front stage: code registers, light-code match and bright detection.
`timescale 1ns / 1ps

module lmpb_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lmpb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lmpb_pkg::CODE_W-1:0]      i_cfg_data,
    input  logic                             i_accept,
    input  lmpb_pkg::t_chan                  i_chan [lmpb_pkg::NUM_LANES],
    input  logic [lmpb_pkg::CODE_W-1:0]      i_light_code,
    output lmpb_pkg::t_chan                  o_chan [lmpb_pkg::NUM_LANES],
    output lmpb_pkg::t_lane_ctl              o_ctl
);
    import lmpb_pkg::*;

    logic [CODE_W-1:0] r_strong;
    logic [CODE_W-1:0] r_medium;
    logic [CODE_W-1:0] r_soft;
    logic              r_valid;
    t_table            r_tbl;
    logic              r_bright;
    t_chan             r_chan [NUM_LANES];

    t_table            n_tbl;
    logic              n_bright;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strong <= STRONG_RST;
            r_medium <= MEDIUM_RST;
            r_soft   <= SOFT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STRONG: r_strong <= i_cfg_data;
                CFG_MEDIUM: r_medium <= i_cfg_data;
                CFG_SOFT:   r_soft   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Priority: strong over medium over soft.
    always_comb begin
        if (i_light_code == r_strong)      n_tbl = TBL_STRONG;
        else if (i_light_code == r_medium) n_tbl = TBL_MEDIUM;
        else if (i_light_code == r_soft)   n_tbl = TBL_SOFT;
        else                               n_tbl = TBL_NONE;
        n_bright = 1'b0;
        for (int k = 0; k < NUM_LANES; k++) begin
            n_bright = n_bright | (i_chan[k] > BRIGHT_LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tbl    <= n_tbl;
            r_bright <= n_bright;
            r_chan   <= i_chan;
        end
    end

    assign o_chan        = r_chan;
    assign o_ctl.valid   = r_valid;
    assign o_ctl.tbl     = r_tbl;
    assign o_ctl.bright  = r_bright;

endmodule

[rtl/lmpb_lane.sv]
// One channel lane: gain multiply, then divide by ten via reciprocal.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmpb_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lmpb_pkg::t_chan       i_chan,
    input  lmpb_pkg::t_lane_ctl   i_ctl,
    output lmpb_pkg::t_chan       o_chan,
    output logic                  o_valid
);
    import lmpb_pkg::*;

    logic                        r_valid_a;
    logic                        r_valid_b;
    logic                        r_keep;
    t_chan                       r_chan;
    logic [PROD_W-1:0]           r_prod;
    t_chan                       r_out;

    logic [GAIN_W-1:0]           n_gain;
    logic [PROD_W-1:0]           n_prod;
    logic                        n_keep;
    logic [PROD_W+RECIP_W-1:0]   n_div;

    always_comb begin
        n_gain = gain_tenths(i_ctl.tbl, i_ctl.bright, i_chan);
        n_prod = PROD_W'(i_chan) * PROD_W'(n_gain);
        n_keep = (i_ctl.tbl == TBL_NONE) || (i_chan >= BRIGHT_LIMIT);
        n_div  = (PROD_W+RECIP_W)'(r_prod) * (PROD_W+RECIP_W)'(RECIP_TENTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_ctl.valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_keep <= n_keep;
        r_chan <= i_chan;
        r_prod <= n_prod;
        r_out  <= r_keep ? r_chan : n_div[RECIP_SH +: CHAN_W];
    end

    assign o_chan  = r_out;
    assign o_valid = r_valid_b;

    `LMPB_ASSERT_RST(a_keep_passes, i_clk, i_rst_n, r_valid_a && r_keep |=> r_out == $past(r_chan), "unmatched or high channel changed")
    `LMPB_ASSERT_RST(a_never_darker, i_clk, i_rst_n, r_valid_a |=> r_out >= $past(r_chan), "brightened channel below input")

endmodule

[rtl/light_map_pixel_brighten.sv]
// Top level of the light-map pixel brighten block.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Light-map pixel brighten.
// Input: a transaction is taken at each rising edge with start high and
// busy low; busy is always low, so one pixel (i_pix_blue/green/red) and its
// 24-bit light-map code (i_light_code) may be given every cycle.
// Output: o_strobe marks o_out_blue/green/red for exactly one cycle. Throughput
// is one pixel per clock; the pipeline has three register stages: code match /
// bright detect, gain multiply in each of three channel lanes, and the
// divide-by-ten reciprocal multiply that feeds the output registers.
// Config: i_cfg_we writes i_cfg_data into the code register picked by
// i_cfg_idx (0 strong, 1 medium, 2 soft); index 3 is ignored. Write only
// while no pixel is in flight.
// Reset (i_rst_n low, synchronous) clears the pipeline valids and restores
// the default codes. The receiver has no way to stall the output; every
// strobed result must be taken on that cycle.
module light_map_pixel_brighten (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [lmpb_pkg::CHAN_W-1:0]      i_pix_blue,
    input  logic [lmpb_pkg::CHAN_W-1:0]      i_pix_green,
    input  logic [lmpb_pkg::CHAN_W-1:0]      i_pix_red,
    input  logic [lmpb_pkg::CODE_W-1:0]      i_light_code,
    input  logic                             i_cfg_we,
    input  logic [lmpb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lmpb_pkg::CODE_W-1:0]      i_cfg_data,
    output logic                             o_strobe,
    output logic [lmpb_pkg::CHAN_W-1:0]      o_out_blue,
    output logic [lmpb_pkg::CHAN_W-1:0]      o_out_green,
    output logic [lmpb_pkg::CHAN_W-1:0]      o_out_red
);
    import lmpb_pkg::*;

    logic                  accept;
    t_chan                 in_chan   [NUM_LANES];
    t_chan                 front_chan[NUM_LANES];
    t_chan                 lane_out  [NUM_LANES];
    t_lane_ctl             front_ctl;
    logic [NUM_LANES-1:0]  lane_valid;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_chan[0] = i_pix_blue;
    assign in_chan[1] = i_pix_green;
    assign in_chan[2] = i_pix_red;

    lmpb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_chan       (in_chan),
        .i_light_code (i_light_code),
        .o_chan       (front_chan),
        .o_ctl        (front_ctl)
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        lmpb_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_chan  (front_chan[g]),
            .i_ctl   (front_ctl),
            .o_chan  (lane_out[g]),
            .o_valid (lane_valid[g])
        );
    end

    // Merge: lanes run in lockstep, so the strobe is their common valid.
    assign o_strobe    = &lane_valid;
    assign o_out_blue  = lane_out[0];
    assign o_out_green = lane_out[1];
    assign o_out_red   = lane_out[2];

    `LMPB_ASSERT_RST(a_latency, i_clk, i_rst_n, accept |-> ##3 o_strobe, "result missing three cycles after start")
    `LMPB_ASSERT_RST(a_no_spurious, i_clk, i_rst_n, !$past(accept, 3) |-> !o_strobe, "strobe without an accepted pixel")
    `LMPB_ASSERT_RST(a_lanes_lockstep, i_clk, i_rst_n, lane_valid == '0 || lane_valid == '1, "lane valids diverged")
    `LMPB_ASSERT_CLK(a_reset_clears, i_clk, !i_rst_n |=> !o_strobe, "strobe right after reset")

endmodule

[tb/tb.sv]
// Self-checking testbench for the light-map pixel brighten block.
`timescale 1ns / 1ps

module tb;
    import lmpb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RST_CYCLES     = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 100;

    typedef struct packed {
        t_chan             blue;
        t_chan             green;
        t_chan             red;
        logic [CODE_W-1:0] code;
    } t_pixel_in;

    typedef struct packed {
        t_chan blue;
        t_chan green;
        t_chan red;
    } t_rgb;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_chan             i_pix_blue = '0;
    t_chan             i_pix_green = '0;
    t_chan             i_pix_red = '0;
    logic [CODE_W-1:0] i_light_code = '0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CODE_W-1:0] i_cfg_data = '0;
    logic              o_strobe;
    t_chan             o_out_blue;
    t_chan             o_out_green;
    t_chan             o_out_red;

    // testbench copy of the code registers
    logic [CODE_W-1:0] strong_code = STRONG_RST;
    logic [CODE_W-1:0] medium_code = MEDIUM_RST;
    logic [CODE_W-1:0] soft_code   = SOFT_RST;

    t_pixel_in pending_pixels[$];
    t_rgb      expected_rgb[$];
    t_pixel_in drv_pixel;
    int        idle_pct = 0;
    int        error_count = 0;
    int        stall_cycles = 0;

    light_map_pixel_brighten i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pix_blue   (i_pix_blue),
        .i_pix_green  (i_pix_green),
        .i_pix_red    (i_pix_red),
        .i_light_code (i_light_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_out_blue   (o_out_blue),
        .o_out_green  (o_out_green),
        .o_out_red    (o_out_red)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_chan scale_chan(t_table tbl, bit lit, t_chan v);
        int band;
        int gain;
        int dim_row[4];
        if (tbl == TBL_NONE || v >= BRIGHT_LIMIT) begin
            return v;
        end
        band = (v < BAND1_MIN) ? 0 : (v < BAND2_MIN) ? 1 : (v < BAND3_MIN) ? 2 : 3;
        case (tbl)
            TBL_STRONG: dim_row = '{40, 20, 17, 13};
            TBL_MEDIUM: dim_row = '{30, 17, 15, 13};
            default:    dim_row = '{20, 15, 13, 12};
        endcase
        if (lit) begin
            gain = (tbl == TBL_SOFT && band == 0) ? 12 : 11;
        end else begin
            gain = dim_row[band];
        end
        return t_chan'((int'(v) * gain) / 10);
    endfunction

    function automatic t_rgb brighten_pixel(t_pixel_in p);
        t_chan  peak;
        bit     lit;
        t_table tbl;
        t_rgb   r;
        peak = p.blue;
        if (p.green > peak) peak = p.green;
        if (p.red > peak) peak = p.red;
        lit = (peak > BRIGHT_LIMIT);
        // strong has priority over medium, medium over soft
        if (p.code == strong_code)      tbl = TBL_STRONG;
        else if (p.code == medium_code) tbl = TBL_MEDIUM;
        else if (p.code == soft_code)   tbl = TBL_SOFT;
        else                            tbl = TBL_NONE;
        r.blue  = scale_chan(tbl, lit, p.blue);
        r.green = scale_chan(tbl, lit, p.green);
        r.red   = scale_chan(tbl, lit, p.red);
        return r;
    endfunction

    function automatic t_chan rand_chan();
        t_chan edges[11];
        edges = '{8'd0, 8'd39, 8'd40, 8'd79, 8'd80, 8'd119, 8'd120,
                  8'd159, 8'd160, 8'd161, 8'd255};
        case ($urandom_range(0, 2))
            0:       return t_chan'($urandom_range(0, 255));
            1:       return t_chan'($urandom_range(0, 165));  // mostly dim pixels
            default: return edges[$urandom_range(0, 10)];
        endcase
    endfunction

    function automatic t_pixel_in rand_pixel();
        t_pixel_in p;
        int        pick;
        logic [CODE_W-1:0] base;
        p.blue  = rand_chan();
        p.green = rand_chan();
        p.red   = rand_chan();
        case ($urandom_range(0, 2))
            0:       base = strong_code;
            1:       base = medium_code;
            default: base = soft_code;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 70)      p.code = base;
        else if (pick < 85) p.code = CODE_W'($urandom);
        else                p.code = base ^ (24'h1 << $urandom_range(0, CODE_W - 1));
        return p;
    endfunction

    task automatic add_pixel(t_chan b, t_chan g, t_chan r, logic [CODE_W-1:0] code);
        t_pixel_in p;
        p.blue  = b;
        p.green = g;
        p.red   = r;
        p.code  = code;
        pending_pixels.push_back(p);
    endtask

    task automatic add_random(int n);
        for (int k = 0; k < n; k++) begin
            pending_pixels.push_back(rand_pixel());
        end
    endtask

    // hold off until every queued pixel has come back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || start || expected_rgb.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_code(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_STRONG: strong_code = data;
            CFG_MEDIUM: medium_code = data;
            CFG_SOFT:   soft_code = data;
            default:    ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_rgb.push_back(brighten_pixel(drv_pixel));
            end
            if (!start || !busy) begin
                if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    drv_pixel = pending_pixels.pop_front();
                    start        <= 1'b1;
                    i_pix_blue   <= drv_pixel.blue;
                    i_pix_green  <= drv_pixel.green;
                    i_pix_red    <= drv_pixel.red;
                    i_light_code <= drv_pixel.code;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_strobe) begin
            if (expected_rgb.size() == 0) begin
                report_mismatch("result with no transaction outstanding", 1, 0);
            end else begin
                want = expected_rgb.pop_front();
                if (o_out_blue != want.blue) report_mismatch("blue", o_out_blue, want.blue);
                if (o_out_green != want.green)
                    report_mismatch("green", o_out_green, want.green);
                if (o_out_red != want.red) report_mismatch("red", o_out_red, want.red);
            end
        end
    end

    // watchdog: cycles without any transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("light_map_pixel_brighten verification failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default codes, directed corners
        idle_pct = 15;
        add_pixel(8'd0, 8'd0, 8'd0, STRONG_RST);
        add_pixel(8'd255, 8'd255, 8'd255, STRONG_RST);
        add_pixel(8'd39, 8'd79, 8'd119, STRONG_RST);
        add_pixel(8'd40, 8'd80, 8'd159, STRONG_RST);
        add_pixel(8'd39, 8'd79, 8'd119, MEDIUM_RST);
        add_pixel(8'd40, 8'd80, 8'd159, MEDIUM_RST);
        add_pixel(8'd39, 8'd79, 8'd119, SOFT_RST);
        add_pixel(8'd40, 8'd80, 8'd159, SOFT_RST);
        // 160 is not bright and stays unchanged
        add_pixel(8'd0, 8'd120, 8'd160, STRONG_RST);
        add_pixel(8'd160, 8'd159, 8'd1, SOFT_RST);
        add_pixel(8'd39, 8'd80, 8'd161, STRONG_RST);
        add_pixel(8'd39, 8'd80, 8'd161, MEDIUM_RST);
        add_pixel(8'd39, 8'd80, 8'd161, SOFT_RST);
        add_pixel(8'd10, 8'd200, 8'd50, SOFT_RST);
        add_pixel(8'd255, 8'd0, 8'd159, MEDIUM_RST);
        // codes that match nothing pass the pixel through
        add_pixel(8'd12, 8'd34, 8'd56, 24'h123456);
        add_pixel(8'd200, 8'd1, 8'd2, 24'hFFFF01);
        add_pixel(8'd5, 8'd60, 8'd100, 24'h000000);
        add_pixel(8'd5, 8'd60, 8'd100, 24'hFFFFFF);
        add_random(110);
        drain();
        add_random(20);
        drain();

        // extreme codes; index 3 must be ignored
        write_code(CFG_STRONG, 24'h000000);
        write_code(CFG_MEDIUM, 24'hFFFFFF);
        write_code(CFG_SOFT, 24'hA5A5A5);
        write_code(CFG_UNUSED, 24'h5A5A5A);
        add_pixel(8'd30, 8'd70, 8'd110, 24'h5A5A5A);
        add_random(120);
        drain();

        // medium and soft share a code: medium wins
        idle_pct = 78;
        write_code(CFG_STRONG, CODE_W'($urandom));
        write_code(CFG_MEDIUM, 24'h3C3C3C);
        write_code(CFG_SOFT, 24'h3C3C3C);
        add_random(120);
        drain();

        // all three equal: strong wins
        write_code(CFG_STRONG, 24'hC3C3C3);
        write_code(CFG_MEDIUM, 24'hC3C3C3);
        write_code(CFG_SOFT, 24'hC3C3C3);
        add_random(120);
        drain();

        // back-to-back traffic with random codes
        idle_pct = 0;
        write_code(CFG_STRONG, CODE_W'($urandom));
        write_code(CFG_MEDIUM, CODE_W'($urandom));
        write_code(CFG_SOFT, CODE_W'($urandom));
        add_random(140);
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("light_map_pixel_brighten verification clean");
        end else begin
            $display("light_map_pixel_brighten verification failed");
        end
        $finish;
    end

endmodule
